### hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/uuid4_pkg.sv
// Shared types, constants and character tables for the UUID generator.
// No dependencies.
package uuid4_pkg;

    localparam int unsigned UUID_CHARS = 36;
    localparam int unsigned POS_W      = 6;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(UUID_CHARS - 1);
    localparam int unsigned RAND_W     = 128;
    localparam logic [7:0] ASCII_HYPHEN = 8'h2d;
    localparam logic [7:0] ASCII_FOUR   = 8'h34;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;

    typedef struct packed {
        logic              rejected;
        logic [RAND_W-1:0] bits;
    } item_t;

    typedef enum logic [1:0] {
        PK_HEX     = 2'd0,
        PK_VARIANT = 2'd1,
        PK_FIXED   = 2'd2
    } pat_kind_t;

    typedef struct packed {
        pat_kind_t  kind;
        logic [7:0] fixed_char;
    } pat_t;

    // Pattern xxxxxxxx-xxxx-4xxx-yxxx-xxxxxxxxxxxx
    function automatic pat_t pattern_at(input logic [POS_W-1:0] pos);
        pat_t p;
        p.kind       = PK_HEX;
        p.fixed_char = 8'h00;
        unique case (pos)
            6'd8, 6'd13, 6'd18, 6'd23: begin
                p.kind       = PK_FIXED;
                p.fixed_char = ASCII_HYPHEN;
            end
            6'd14: begin
                p.kind       = PK_FIXED;
                p.fixed_char = ASCII_FOUR;
            end
            6'd19: begin
                p.kind = PK_VARIANT;
            end
            default: begin
                p.kind = PK_HEX;
            end
        endcase
        return p;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = ASCII_ZERO + {4'd0, nib};
        end else begin
            c = ASCII_LOWER_A + {4'd0, nib - 4'd10};
        end
        return c;
    endfunction

endpackage

### hdl/uuid4_string_generator.sv
// UUID v4 text generator: seed in, 36 ASCII characters out (one for a zero seed),
// last one flagged. A seed passes through the queue, the current-item registers
// and the output register. Throughput: one character per cycle while m_ready allows,
// set by the character sequencer; a zero seed gives one rejection.
// Reset (aresetn low, synchronous) empties the queue and the output register.
module uuid4_string_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_seed_low,
    input  logic [63:0] s_seed_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_character,
    output logic        m_last_char,
    output logic        m_seed_rejected
);

    uuid4_pkg::item_t front_item;
    uuid4_pkg::item_t q_item;
    logic             q_full, q_valid, q_pop, push;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    uuid4_front u_front (
        .s_seed_low  (s_seed_low),
        .s_seed_high (s_seed_high),
        .item        (front_item)
    );

    uuid4_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (q_item)
    );

    uuid4_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_character     (m_character),
        .m_last_char     (m_last_char),
        .m_seed_rejected (m_seed_rejected)
    );

endmodule

### hdl/uuid4_front.sv
// Front end: runs two xorshift128+ steps on the seed and flags a zero seed.
// Depends on uuid4_pkg.
module uuid4_front (
    input  logic [63:0]     s_seed_low,
    input  logic [63:0]     s_seed_high,
    output uuid4_pkg::item_t item
);

    logic [63:0] a1, nb1, a2, nb2, r0, r1;

    always_comb begin
        a1  = s_seed_low ^ (s_seed_low << 23);
        nb1 = a1 ^ s_seed_high ^ (a1 >> 18) ^ (s_seed_high >> 5);
        r0  = nb1 + s_seed_high;
        a2  = s_seed_high ^ (s_seed_high << 23);
        nb2 = a2 ^ nb1 ^ (a2 >> 18) ^ (nb1 >> 5);
        r1  = nb2 + nb1;
        item.rejected = (s_seed_low == 64'd0) && (s_seed_high == 64'd0);
        item.bits     = {r1, r0};
    end

endmodule

### hdl/uuid4_queue.sv
// Two-entry queue between the front end and the character sequencer.
// Depends on uuid4_pkg.
module uuid4_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  uuid4_pkg::item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output uuid4_pkg::item_t pop_item
);

    uuid4_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/uuid4_back.sv
// Back end: walks the UUID pattern and emits one character per transfer.
// Depends on uuid4_pkg.
module uuid4_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  uuid4_pkg::item_t q_item,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_character,
    output logic             m_last_char,
    output logic             m_seed_rejected
);

    logic                               cur_valid_reg, cur_valid_next;
    logic                               cur_rej_reg, cur_rej_next;
    logic [uuid4_pkg::RAND_W-1:0]       bits_reg, bits_next;
    logic [uuid4_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic                               m_valid_reg, m_valid_next;
    logic [7:0]                         char_reg, char_next;
    logic                               last_reg, last_next;
    logic                               rej_reg, rej_next;

    uuid4_pkg::pat_t pat;
    logic            emit, finish, consume;
    logic [7:0]      code;

    always_comb begin
        pat     = uuid4_pkg::pattern_at(pos_reg);
        consume = 1'b0;
        unique case (pat.kind)
            uuid4_pkg::PK_HEX: begin
                code    = uuid4_pkg::hex_ascii(bits_reg[3:0]);
                consume = 1'b1;
            end
            uuid4_pkg::PK_VARIANT: begin
                code    = uuid4_pkg::hex_ascii({2'b10, bits_reg[1:0]});
                consume = 1'b1;
            end
            default: begin
                code = pat.fixed_char;
            end
        endcase

        emit   = cur_valid_reg && (!m_valid_reg || m_ready);
        finish = emit && (cur_rej_reg || (pos_reg == uuid4_pkg::LAST_POS));
        q_pop  = q_valid && (!cur_valid_reg || finish);

        cur_valid_next = cur_valid_reg;
        cur_rej_next   = cur_rej_reg;
        bits_next      = bits_reg;
        pos_next       = pos_reg;
        if (q_pop) begin
            cur_valid_next = 1'b1;
            cur_rej_next   = q_item.rejected;
            bits_next      = q_item.bits;
            pos_next       = '0;
        end else if (finish) begin
            cur_valid_next = 1'b0;
        end else if (emit) begin
            pos_next = pos_reg + 1'b1;
            if (consume) begin
                // advance to the next random nibble
                bits_next = bits_reg >> 4;
            end
        end

        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        rej_next     = rej_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            char_next    = cur_rej_reg ? 8'h00 : code;
            last_next    = cur_rej_reg || (pos_reg == uuid4_pkg::LAST_POS);
            rej_next     = cur_rej_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_rej_reg <= cur_rej_next;
        bits_reg    <= bits_next;
        pos_reg     <= pos_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
        rej_reg     <= rej_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_character     = char_reg;
    assign m_last_char     = last_reg;
    assign m_seed_rejected = rej_reg;

endmodule

### hdl/uuid4_checker.sv
// Port-level checks for the UUID generator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module uuid4_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_character,
    input logic        m_last_char,
    input logic        m_seed_rejected
);

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped")
    `ASSERT_CLK(a_rej_last, aclk, aresetn, m_valid && m_seed_rejected |-> m_last_char, "reject not last")
    `ASSERT_CLK(a_rej_zero, aclk, aresetn, m_valid && m_seed_rejected |-> m_character == 8'h00, "reject char")
    `ASSERT_CLK_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "valid after reset")

endmodule

bind uuid4_string_generator uuid4_checker u_chk (.*);

### tb/sv/tb_uuid4_string_generator.sv
`timescale 1ns / 100ps
// Testbench for uuid4_string_generator: sends seeds, predicts the 36-character UUID text
// (or a rejection for a zero seed) and checks every character transfer in order.
// Depends on uuid4_pkg and the uuid4_string_generator RTL.
module tb_uuid4_string_generator;

    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam logic [8*uuid4_pkg::UUID_CHARS-1:0] UUID_PATTERN =
        "xxxxxxxx-xxxx-4xxx-yxxx-xxxxxxxxxxxx";
    localparam logic [8*16-1:0] HEX_DIGITS = "0123456789abcdef";
    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
        logic       seed_rejected;
    } uuid_char_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_seed_low = '0;
    logic [63:0] s_seed_high = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_character;
    logic        m_last_char;
    logic        m_seed_rejected;

    uuid_char_t  chars_due[$];
    uuid_char_t  char_head;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;

    uuid4_string_generator DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_seed_low     (s_seed_low),
        .s_seed_high    (s_seed_high),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_character    (m_character),
        .m_last_char    (m_last_char),
        .m_seed_rejected(m_seed_rejected)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Two xorshift128+ steps give 128 random bits; nibble k sits at bits 4k+3..4k.
    function automatic void predict_uuid_text(input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0]  w0;
        logic [63:0]  w1;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  nb;
        logic [127:0] rnd;
        logic [7:0]   pat;
        logic [3:0]   nib;
        uuid_char_t   c;
        int           i;
        int           k;
        if (lo == '0 && hi == '0) begin
            c.character = 8'h00;
            c.last_char = 1'b1;
            c.seed_rejected = 1'b1;
            chars_due.push_back(c);
            return;
        end
        w0 = lo;
        w1 = hi;
        for (i = 0; i < 2; i++) begin
            a = w0;
            b = w1;
            w0 = b;
            a = a ^ (a << 23);
            nb = a ^ b ^ (a >> 18) ^ (b >> 5);
            w1 = nb;
            rnd[64*i +: 64] = nb + b;
        end
        k = 0;
        for (i = 0; i < uuid4_pkg::UUID_CHARS; i++) begin
            pat = UUID_PATTERN[8*(uuid4_pkg::UUID_CHARS-1-i) +: 8];
            nib = rnd[4*k +: 4];
            if (pat == "x") begin
                c.character = HEX_DIGITS[8*(15-nib) +: 8];
                k++;
            end else if (pat == "y") begin
                c.character = HEX_DIGITS[8*(15-(8+nib[1:0])) +: 8];
                k++;
            end else begin
                c.character = pat;
            end
            c.last_char = (i == uuid4_pkg::UUID_CHARS - 1);
            c.seed_rejected = 1'b0;
            chars_due.push_back(c);
        end
    endfunction

    // Hold the seed until it transfers; valid stays high for a back-to-back seed.
    task automatic send_seed(input logic [63:0] lo, input logic [63:0] hi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_seed_low <= lo;
        s_seed_high <= hi;
        do @(posedge aclk); while (!s_ready);
        predict_uuid_text(lo, hi);
    endtask

    task automatic send_random_seeds(input int n);
        int          i;
        int unsigned pick;
        logic [63:0] lo;
        logic [63:0] hi;
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            if (pick < 6) begin
                lo = '0;
                hi = '0;
            end else if (pick < 11) begin
                lo = '0;
            end else if (pick < 16) begin
                hi = '0;
            end else if (pick < 22) begin
                lo = 64'd1 << $urandom_range(63);
                hi = 64'd1 << $urandom_range(63);
            end
            send_seed(lo, hi);
        end
    endtask

    // Drop valid after the last transfer and wait for every character to come out.
    task automatic finish_phase();
        s_valid <= 1'b0;
        while (chars_due.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_seed('0, '0);
        send_seed('0, '0);
        send_seed(64'd1, '0);
        send_seed('0, 64'd1);
        send_seed(ALL_ONES, ALL_ONES);
        send_seed('0, '0);
        send_seed(ALL_ONES, '0);
        send_seed('0, ALL_ONES);
        send_seed(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        send_seed(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        send_seed(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_seed(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        send_seed('0, '0);
        finish_phase();
    endtask

    task automatic test_random_streaming();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random_seeds(77);
        finish_phase();
    endtask

    task automatic test_random_sender_gaps();
        send_idle_pct = 80;
        recv_stall_pct = 0;
        send_random_seeds(77);
        finish_phase();
    endtask

    task automatic test_random_receiver_stalls();
        send_idle_pct = 0;
        recv_stall_pct = 80;
        send_random_seeds(77);
        finish_phase();
    endtask

    task automatic test_random_mixed_gaps();
        send_idle_pct = 26;
        recv_stall_pct = 26;
        send_random_seeds(77);
        finish_phase();
    endtask

    // Compare each character transfer with the oldest prediction, then pick the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (chars_due.size() == 0) begin
                $error("unexpected character transfer: character %h last %b rejected %b",
                       m_character, m_last_char, m_seed_rejected);
                error_count++;
            end else begin
                char_head = chars_due.pop_front();
                if (m_character !== char_head.character) begin
                    $error("character: expected %h, got %h", char_head.character, m_character);
                    error_count++;
                end
                if (m_last_char !== char_head.last_char) begin
                    $error("last_char: expected %b, got %b", char_head.last_char, m_last_char);
                    error_count++;
                end
                if (m_seed_rejected !== char_head.seed_rejected) begin
                    $error("seed_rejected: expected %b, got %b",
                           char_head.seed_rejected, m_seed_rejected);
                    error_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort when neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_streaming();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_mixed_gaps();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
